// ===== rtl/tcp_segmentation_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// TCP segmentation header parser - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TCP_SEGMENTATION_HEADER_PARSER_MACROS_SVH
`define TCP_SEGMENTATION_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define TCPSHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPSHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcpshp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpshp_pkg
// Beat types, parse phases and fixed constants of the TCP segmentation
// header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpshp_pkg;

  localparam int unsigned TagCntW = 3;
  localparam int unsigned ExtCntW = 4;

  localparam logic [15:0] MtuReset     = 16'd1500;
  localparam logic [7:0]  EthHdrBytes  = 8'd14;
  localparam logic [15:0] EtypeVlan    = 16'h8100;
  localparam logic [15:0] EtypeQinq    = 16'h88A8;
  localparam logic [15:0] EtypeIpv4    = 16'h0800;
  localparam logic [15:0] EtypeIpv6    = 16'h86DD;
  localparam logic [7:0]  ProtoTcp     = 8'd6;
  localparam logic [7:0]  ProtoUdp     = 8'd17;
  localparam logic [7:0]  ProtoIcmpv6  = 8'd58;
  localparam logic [1:0]  IpVerNone    = 2'd0;
  localparam logic [1:0]  IpVer4       = 2'd1;
  localparam logic [1:0]  IpVer6       = 2'd2;

  typedef enum logic [2:0] {
    PH_ETH  = 3'd0,
    PH_VLAN = 3'd1,
    PH_IPV4 = 3'd2,
    PH_IPV6 = 3'd3,
    PH_EXT  = 3'd4,
    PH_SKIP = 3'd5,
    PH_TCP  = 3'd6,
    PH_DONE = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic        offload;
    logic [1:0]  ip_version;
    logic [7:0]  l2_length;
    logic [15:0] l3_length;
    logic [5:0]  l4_length;
    logic [15:0] segment_size;
  } out_beat_t;

  // end-of-frame parse summary handed to the result stage
  typedef struct packed {
    logic        saw_tcp;
    logic        is_v4;
    logic [15:0] byte_count;
    logic [7:0]  l2_bytes;
    logic [15:0] l3_bytes;
    logic [5:0]  l4_bytes;
  } snap_t;

endpackage

`default_nettype wire

// ===== rtl/tcpshp_parser.sv =====
// ----------------------------------------------------------------------------
// tcpshp_parser
// Byte-serial header walk: VLAN tags, IPv4/IPv6 with extension headers and
// the TCP data offset. On the last byte it registers a frame summary.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpshp_parser #(
  parameter int unsigned MAX_VLAN_TAGS   = 4,
  parameter int unsigned MAX_EXT_HEADERS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tcpshp_pkg::in_beat_t in_data_i,
  output logic                      snap_valid_o,
  input  wire logic                 snap_take_i,
  output tcpshp_pkg::snap_t         snap_o
);
  import tcpshp_pkg::*;

  logic [15:0]        byte_count_q, byte_count_d;
  phase_e             phase_q, phase_d;
  logic [15:0]        cur_type_q, cur_type_d;
  logic [7:0]         l2_q, l2_d;
  logic [15:0]        l3_q, l3_d;
  logic [5:0]         l4_q, l4_d;
  logic [7:0]         nh_q, nh_d;
  logic [15:0]        hend_q, hend_d;
  logic [TagCntW-1:0] tag_q, tag_d;
  logic [ExtCntW-1:0] ext_q, ext_d;
  logic               saw_q, saw_d;
  logic               snap_valid_q, snap_valid_d;
  snap_t              snap_q, snap_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] off;
  logic [15:0] ext_len;
  logic [15:0] type_w;

  // next phase after an EtherType is known
  function automatic phase_e l2_next(input logic [15:0] etype,
                                     input logic [TagCntW-1:0] tags);
    phase_e ph;
    if (etype == EtypeVlan || etype == EtypeQinq) begin
      ph = (tags < TagCntW'(MAX_VLAN_TAGS)) ? PH_VLAN : PH_DONE;
    end else if (etype == EtypeIpv4) begin
      ph = PH_IPV4;
    end else if (etype == EtypeIpv6) begin
      ph = PH_IPV6;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  // next phase inside the IPv6 header chain
  function automatic phase_e v6_next(input logic [7:0] nh,
                                     input logic [ExtCntW-1:0] exts);
    phase_e ph;
    if (nh == ProtoTcp) begin
      ph = PH_TCP;
    end else if (nh == ProtoUdp || nh == ProtoIcmpv6) begin
      ph = PH_DONE;
    end else if (exts < ExtCntW'(MAX_EXT_HEADERS)) begin
      ph = PH_EXT;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  // a last beat needs room in the summary register
  assign in_stall_o = snap_valid_q && !snap_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_data_i.data;
  assign off        = byte_count_q - hend_q;
  assign ext_len    = (16'(b) + 16'd1) << 3;
  assign type_w     = {cur_type_q[15:8], b};

  // per-byte parse update, then frame clear on last
  always_comb begin
    byte_count_d = byte_count_q;
    phase_d      = phase_q;
    cur_type_d   = cur_type_q;
    l2_d         = l2_q;
    l3_d         = l3_q;
    l4_d         = l4_q;
    nh_d         = nh_q;
    hend_d       = hend_q;
    tag_d        = tag_q;
    ext_d        = ext_q;
    saw_d        = saw_q;
    if (accept) begin
      unique case (phase_q)
        PH_ETH: begin
          if (byte_count_q == 16'd12) begin
            cur_type_d = {b, 8'h00};
          end else if (byte_count_q == 16'd13) begin
            cur_type_d = type_w;
            hend_d     = 16'(EthHdrBytes);
            phase_d    = l2_next(type_w, tag_q);
          end
        end
        PH_VLAN: begin
          if (off == 16'd2) begin
            cur_type_d = {b, 8'h00};
          end else if (off == 16'd3) begin
            cur_type_d = type_w;
            l2_d       = l2_q + 8'd4;
            hend_d     = hend_q + 16'd4;
            tag_d      = tag_q + TagCntW'(1);
            phase_d    = l2_next(type_w, tag_q + TagCntW'(1));
          end
        end
        PH_IPV4: begin
          if (off == 16'd0) begin
            l3_d = {10'd0, b[3:0], 2'b00};
          end else if (off == 16'd9) begin
            nh_d = b;
            if (l3_q < 16'd20 || b != ProtoTcp) begin
              phase_d = PH_DONE;
            end else begin
              hend_d  = hend_q + l3_q;
              phase_d = PH_TCP;
            end
          end
        end
        PH_IPV6: begin
          if (off == 16'd6) begin
            nh_d = b;
          end else if (off == 16'd39) begin
            l3_d    = 16'd40;
            hend_d  = hend_q + 16'd40;
            phase_d = v6_next(nh_q, ext_q);
          end
        end
        PH_EXT: begin
          if (off == 16'd0) begin
            nh_d = b;
          end else if (off == 16'd1) begin
            l3_d    = l3_q + ext_len;
            hend_d  = hend_q + ext_len;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (byte_count_q + 16'd1 == hend_q) begin
            ext_d   = ext_q + ExtCntW'(1);
            phase_d = v6_next(nh_q, ext_q + ExtCntW'(1));
          end
        end
        PH_TCP: begin
          if (off == 16'd12) begin
            l4_d    = {b[7:4], 2'b00};
            saw_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
        end
      endcase
      if (byte_count_q != 16'hFFFF) begin
        byte_count_d = byte_count_q + 16'd1;
      end
    end

    snap_next.saw_tcp    = saw_d;
    snap_next.is_v4      = (cur_type_d == EtypeIpv4);
    snap_next.byte_count = byte_count_d;
    snap_next.l2_bytes   = l2_d;
    snap_next.l3_bytes   = l3_d;
    snap_next.l4_bytes   = l4_d;

    // frame done: back to the Ethernet header
    if (accept && in_data_i.last) begin
      byte_count_d = '0;
      phase_d      = PH_ETH;
      cur_type_d   = '0;
      l2_d         = EthHdrBytes;
      l3_d         = '0;
      l4_d         = '0;
      nh_d         = '0;
      hend_d       = '0;
      tag_d        = '0;
      ext_d        = '0;
      saw_d        = 1'b0;
    end
  end

  // summary register occupancy
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (accept && in_data_i.last) begin
      snap_valid_d = 1'b1;
    end else if (snap_take_i) begin
      snap_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      phase_q      <= PH_ETH;
      cur_type_q   <= '0;
      l2_q         <= EthHdrBytes;
      l3_q         <= '0;
      l4_q         <= '0;
      nh_q         <= '0;
      hend_q       <= '0;
      tag_q        <= '0;
      ext_q        <= '0;
      saw_q        <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      phase_q      <= phase_d;
      cur_type_q   <= cur_type_d;
      l2_q         <= l2_d;
      l3_q         <= l3_d;
      l4_q         <= l4_d;
      nh_q         <= nh_d;
      hend_q       <= hend_d;
      tag_q        <= tag_d;
      ext_q        <= ext_d;
      saw_q        <= saw_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  // summary payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last) begin
      snap_q <= snap_next;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

`default_nettype wire

// ===== rtl/tcpshp_result.sv =====
// ----------------------------------------------------------------------------
// tcpshp_result
// Offload decision and segment size from the frame summary, held in the
// output register until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpshp_result (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       mtu_i,
  input  wire logic              snap_valid_i,
  output logic                   snap_take_o,
  input  wire tcpshp_pkg::snap_t snap_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tcpshp_pkg::out_beat_t  out_data_o
);
  import tcpshp_pkg::*;

  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;
  logic        load_ok;
  logic        offload;
  logic [15:0] payload_len;
  logic [16:0] need;

  assign load_ok     = !out_valid_q || !out_stall_i;
  assign snap_take_o = snap_valid_i && load_ok;

  // frame bytes past L2 against the MTU
  assign payload_len = snap_i.byte_count - 16'(snap_i.l2_bytes);
  assign offload     = snap_i.saw_tcp
                    && (snap_i.byte_count > 16'(snap_i.l2_bytes))
                    && (payload_len > mtu_i);
  assign need        = 17'(snap_i.l3_bytes) + 17'(snap_i.l4_bytes);

  // result fields, all zero without offload
  always_comb begin
    out_d = '0;
    if (offload) begin
      out_d.offload      = 1'b1;
      out_d.ip_version   = snap_i.is_v4 ? IpVer4 : IpVer6;
      out_d.l2_length    = snap_i.l2_bytes;
      out_d.l3_length    = snap_i.l3_bytes;
      out_d.l4_length    = snap_i.l4_bytes;
      out_d.segment_size = (need >= 17'(mtu_i)) ? 16'd0 : (mtu_i - need[15:0]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (snap_take_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/tcp_segmentation_header_parser.sv =====
// ----------------------------------------------------------------------------
// tcp_segmentation_header_parser
// Byte-serial Ethernet/VLAN/IPv4/IPv6/TCP header parser that flags frames
// needing TCP segmentation offload and reports the header lengths.
//
//   channel  dir  handshake          beat
//   in       in   valid / stall      one frame byte + last flag
//   out      out  valid / stall      one result per frame
//   cfg      in   valid / ready      link MTU (16 bits)
//
// One byte is taken every cycle while in_stall_o is low; the parse state
// updates in the cycle the byte is taken. A result passes from the summary
// register through the result logic into the output register.
// Reset: async active low; MTU returns to 1500, parse state to frame start.
// With the output stalled, one further frame summary is held; input stalls
// only when that summary register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segmentation_header_parser #(
  parameter int unsigned MAX_VLAN_TAGS   = 4,
  parameter int unsigned MAX_EXT_HEADERS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire tcpshp_pkg::in_beat_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output tcpshp_pkg::out_beat_t      out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [15:0]           cfg_data_i
);
  import tcpshp_pkg::*;

  `include "tcp_segmentation_header_parser_macros.svh"

  logic [15:0] mtu_q, mtu_d;
  logic        snap_valid;
  logic        snap_take;
  snap_t       snap;

  // MTU register, always writable
  assign cfg_ready_o = 1'b1;
  assign mtu_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mtu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
    end else begin
      mtu_q <= mtu_d;
    end
  end

  tcpshp_parser #(
    .MAX_VLAN_TAGS   (MAX_VLAN_TAGS),
    .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .snap_valid_o (snap_valid),
    .snap_take_i  (snap_take),
    .snap_o       (snap)
  );

  tcpshp_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mtu_i        (mtu_q),
    .snap_valid_i (snap_valid),
    .snap_take_o  (snap_take),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // a taken last beat always lands in the summary register
  `TCPSHP_ASSERT_NEXT(a_last_to_snap, in_valid_i && !in_stall_o && in_data_i.last, snap_valid, "last beat lost")
  // input only stalls behind a pending summary
  `TCPSHP_ASSERT_NOW(a_stall_cause, in_stall_o, snap_valid && out_valid_o && out_stall_i, "spurious input stall")
  // a frame without offload reports nothing else
  `TCPSHP_ASSERT_NOW(a_no_offload_zero, out_valid_o && !out_data_o.offload, out_data_o.ip_version == IpVerNone && out_data_o.l2_length == 8'd0 && out_data_o.segment_size == 16'd0, "fields set without offload")
  // offloaded frames are IPv4 or IPv6
  `TCPSHP_ASSERT_NOW(a_offload_ip, out_valid_o && out_data_o.offload, out_data_o.ip_version == IpVer4 || out_data_o.ip_version == IpVer6, "offload without IP version")

endmodule

`default_nettype wire
